// ===== rtl/core/fsr_pkg.sv =====
// Shared types, constants and command codes of the file segment reassembly block.
`timescale 1ns / 1ps
`default_nettype none
package fsr_pkg;

  localparam int unsigned SEGMENTS_DEF = 32768;
  localparam int unsigned SEG_BYTES    = 5;
  localparam int unsigned SEG_W        = 8 * SEG_BYTES;
  localparam int unsigned SIZE_W       = 18;
  localparam int unsigned ADDR_W       = 16;
  localparam int unsigned BLK_W        = 16;
  // Segment counts reach at most 65536 for the largest memory.
  localparam int unsigned NEED_W       = 17;

  // ceil(size / 5) = floor((size + 4) * RECIP_M / 2**RECIP_SH) for any 19-bit sum.
  localparam int unsigned RECIP_SH     = 21;
  localparam int unsigned RECIP_M      = ((2 ** RECIP_SH) + SEG_BYTES - 1) / SEG_BYTES;

  localparam logic [1:0] CMD_RECV    = 2'd0;
  localparam logic [1:0] CMD_READ    = 2'd1;
  localparam logic [1:0] CMD_DELIVER = 2'd2;

  typedef struct packed {
    logic [1:0]       cmd;
    logic             toggle;
    logic [ADDR_W-1:0] seg_index;
    logic [BLK_W-1:0] block_two;
    logic [BLK_W-1:0] block_three;
    logic [BLK_W-1:0] block_four;
  } in_t;

  typedef struct packed {
    logic       file_complete;
    logic       segment_present;
    logic [7:0] byte_zero;
    logic [7:0] byte_one;
    logic [7:0] byte_two;
    logic [7:0] byte_three;
    logic [7:0] byte_four;
  } out_t;

endpackage
`default_nettype wire

// ===== rtl/core/fsr_ram.sv =====
// Single-port synchronous RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module fsr_ram #(
  parameter int unsigned W     = fsr_pkg::SEG_W,
  parameter int unsigned DEPTH = fsr_pkg::SEGMENTS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [W-1:0]             wdata,
  output logic      [W-1:0]             rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

// ===== rtl/core/fsr_need_div.sv =====
// Two-stage reciprocal multiplier that turns a byte length into a segment count.
`timescale 1ns / 1ps
`default_nettype none
module fsr_need_div (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        go,
  input  wire logic [fsr_pkg::SIZE_W-1:0]  size,
  output logic      [fsr_pkg::NEED_W-1:0]  need,
  output logic                             done
);
  import fsr_pkg::*;

  localparam int unsigned SUM_W  = SIZE_W + 1;
  localparam int unsigned PROD_W = 2 * SUM_W;

  logic [SUM_W-1:0]  sum;
  logic [PROD_W-1:0] prod_r;
  logic              go_r;

  assign sum = {1'b0, size} + SUM_W'(SEG_BYTES - 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      go_r <= 1'b0;
      done <= 1'b0;
    end else begin
      go_r <= go;
      done <= go_r;
    end
    if (go) begin
      prod_r <= PROD_W'(sum) * PROD_W'(RECIP_M);
    end
    if (go_r) begin
      need <= prod_r[RECIP_SH +: NEED_W];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/fsr_ctrl.sv =====
// Command sequencer: map clearing, recount walk and read-modify-write of both memories.
`timescale 1ns / 1ps
`default_nettype none
module fsr_ctrl #(
  parameter int unsigned SEGMENTS = fsr_pkg::SEGMENTS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire fsr_pkg::in_t                  in_data,
  output logic                               busy,
  output logic                               out_valid,
  output fsr_pkg::out_t                      out_data,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [fsr_pkg::SIZE_W-1:0]    cfg_data,
  output logic [$clog2(SEGMENTS)-1:0]        map_addr,
  output logic                               map_we,
  output logic                               map_wd,
  input  wire logic                          map_rd,
  output logic [$clog2(SEGMENTS)-1:0]        seg_addr,
  output logic                               seg_we,
  output logic [fsr_pkg::SEG_W-1:0]          seg_wd,
  input  wire logic [fsr_pkg::SEG_W-1:0]     seg_rd,
  output logic                               div_go,
  output logic [fsr_pkg::SIZE_W-1:0]         div_size,
  input  wire logic [fsr_pkg::NEED_W-1:0]    div_need,
  input  wire logic                          div_done
);
  import fsr_pkg::*;

  localparam int unsigned AW = $clog2(SEGMENTS);
  localparam int unsigned CW = $clog2(SEGMENTS + 1);
  localparam logic [ADDR_W:0] SEG_LIM  = (ADDR_W + 1)'(SEGMENTS);
  localparam logic [SIZE_W:0] MAX_SIZE = (SIZE_W + 1)'(SEGMENTS * SEG_BYTES);

  typedef enum logic [2:0] {
    S_BOOT, S_IDLE, S_DIV, S_CNT, S_TCLR, S_RD, S_UPD
  } state_t;

  state_t            state_r, state_nxt;
  logic [AW-1:0]     clr_idx_r, clr_idx_nxt;
  logic [CW-1:0]     cnt_idx_r, cnt_idx_nxt;
  logic              rdp_r, rdp_nxt;
  logic              pend_r, pend_nxt;
  logic [SIZE_W-1:0] size_r, size_nxt;
  logic [CW-1:0]     need_r, need_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic              last_tog_r, last_tog_nxt;
  logic              dlv_r, dlv_nxt;
  logic              any_r, any_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_t              out_data_r, out_data_nxt;
  logic [1:0]        cmd_r, cmd_nxt;
  logic [AW-1:0]     addr_r, addr_nxt;
  logic              inr_r, inr_nxt;
  logic [SEG_W-1:0]  data_r, data_nxt;

  logic cfg_acc, in_acc, size_ok, is_recv, is_read, need_hit, inc;

  assign busy      = (state_r != S_IDLE) || pend_r;
  assign cfg_ready = ((state_r == S_IDLE && !start) || state_r == S_BOOT) && !pend_r;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign in_acc    = start && !busy;
  assign size_ok   = {1'b0, cfg_data} <= MAX_SIZE;
  assign div_size  = cfg_data;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign is_recv  = cmd_r == CMD_RECV;
  assign is_read  = cmd_r == CMD_READ;
  assign need_hit = CW'(addr_r) < need_r;
  // A fresh mark below the needed count moves the count by one.
  assign inc      = is_recv && inr_r && !map_rd && need_hit;

  assign seg_addr = addr_r;
  assign seg_wd   = data_r;

  always_comb begin
    state_nxt     = state_r;
    clr_idx_nxt   = clr_idx_r;
    cnt_idx_nxt   = cnt_idx_r;
    rdp_nxt       = rdp_r;
    pend_nxt      = pend_r;
    size_nxt      = size_r;
    need_nxt      = need_r;
    cnt_nxt       = cnt_r;
    last_tog_nxt  = last_tog_r;
    dlv_nxt       = dlv_r;
    any_nxt       = any_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    cmd_nxt       = cmd_r;
    addr_nxt      = addr_r;
    inr_nxt       = inr_r;
    data_nxt      = data_r;
    map_addr      = addr_r;
    map_we        = 1'b0;
    map_wd        = 1'b0;
    seg_we        = 1'b0;
    div_go        = 1'b0;

    if (div_done) begin
      need_nxt = div_need[CW-1:0];
      pend_nxt = 1'b0;
    end

    unique case (state_r)
      S_BOOT: begin
        map_addr    = clr_idx_r;
        map_we      = 1'b1;
        clr_idx_nxt = clr_idx_r + AW'(1);
        if (&clr_idx_r) begin
          state_nxt = S_IDLE;
        end
        // The map is all clear here, so a new length needs no recount.
        if (cfg_acc && size_ok) begin
          size_nxt = cfg_data;
          div_go   = 1'b1;
          pend_nxt = 1'b1;
        end
      end
      S_IDLE: begin
        if (cfg_acc) begin
          if (size_ok) begin
            size_nxt  = cfg_data;
            div_go    = 1'b1;
            pend_nxt  = 1'b1;
            state_nxt = S_DIV;
          end
        end else if (in_acc) begin
          cmd_nxt  = in_data.cmd;
          addr_nxt = in_data.seg_index[AW-1:0];
          inr_nxt  = {1'b0, in_data.seg_index} < SEG_LIM;
          data_nxt = {in_data.block_two[7:0], in_data.block_three, in_data.block_four};
          state_nxt = S_RD;
          case (in_data.cmd)
            CMD_RECV: begin
              any_nxt      = 1'b1;
              last_tog_nxt = in_data.toggle;
              if (in_data.toggle != last_tog_r) begin
                dlv_nxt   = 1'b0;
                cnt_nxt   = '0;
                state_nxt = S_TCLR;
              end
            end
            CMD_DELIVER: dlv_nxt = 1'b1;
            default: ;
          endcase
        end
      end
      S_DIV: begin
        if (div_done) begin
          cnt_nxt     = '0;
          cnt_idx_nxt = '0;
          rdp_nxt     = 1'b0;
          state_nxt   = S_CNT;
        end
      end
      S_CNT: begin
        // One map read per cycle; the mark comes back in the next cycle.
        map_addr = cnt_idx_r[AW-1:0];
        if (rdp_r) begin
          cnt_nxt = cnt_r + CW'(map_rd);
        end
        if (cnt_idx_r < need_r) begin
          cnt_idx_nxt = cnt_idx_r + CW'(1);
          rdp_nxt     = 1'b1;
        end else begin
          rdp_nxt = 1'b0;
          if (!rdp_r) begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_TCLR: begin
        map_addr    = clr_idx_r;
        map_we      = 1'b1;
        clr_idx_nxt = clr_idx_r + AW'(1);
        if (&clr_idx_r) begin
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        state_nxt = S_UPD;
      end
      S_UPD: begin
        map_wd  = 1'b1;
        map_we  = is_recv && inr_r;
        seg_we  = is_recv && inr_r;
        cnt_nxt = cnt_r + CW'(inc);
        out_valid_nxt = 1'b1;
        out_data_nxt.file_complete = !dlv_r && (size_r != '0) && any_r
                                     && (cnt_nxt >= need_r);
        out_data_nxt.segment_present = is_read && inr_r && map_rd;
        if (is_read && inr_r) begin
          out_data_nxt.byte_zero  = seg_rd[39:32];
          out_data_nxt.byte_one   = seg_rd[31:24];
          out_data_nxt.byte_two   = seg_rd[23:16];
          out_data_nxt.byte_three = seg_rd[15:8];
          out_data_nxt.byte_four  = seg_rd[7:0];
        end else begin
          out_data_nxt.byte_zero  = '0;
          out_data_nxt.byte_one   = '0;
          out_data_nxt.byte_two   = '0;
          out_data_nxt.byte_three = '0;
          out_data_nxt.byte_four  = '0;
        end
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_BOOT;
      clr_idx_r   <= '0;
      cnt_idx_r   <= '0;
      rdp_r       <= 1'b0;
      pend_r      <= 1'b0;
      size_r      <= '0;
      need_r      <= '0;
      cnt_r       <= '0;
      last_tog_r  <= 1'b0;
      dlv_r       <= 1'b0;
      any_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      cnt_idx_r   <= cnt_idx_nxt;
      rdp_r       <= rdp_nxt;
      pend_r      <= pend_nxt;
      size_r      <= size_nxt;
      need_r      <= need_nxt;
      cnt_r       <= cnt_nxt;
      last_tog_r  <= last_tog_nxt;
      dlv_r       <= dlv_nxt;
      any_r       <= any_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
    cmd_r      <= cmd_nxt;
    addr_r     <= addr_nxt;
    inr_r      <= inr_nxt;
    data_r     <= data_nxt;
  end

endmodule
`default_nettype wire

// ===== rtl/core/file_segment_reassembly.sv =====
// Top level of the file segment reassembly block.
`timescale 1ns / 1ps
`default_nettype none
// Rebuilds a file sent as 5-byte segments in two single-port RAMs: a received
// map of one bit per segment and a 40-bit segment store.
// Commands: an item is taken on a clock edge with start high and busy low.
// Receive stores a segment and sets its mark; read returns a segment and its
// mark; deliver sets the delivered flag. Each command gives one result beat on
// out_data, marked by a one-cycle out_valid strobe; the receiver cannot stall.
// Order: an accepted item passes a read state (S_RD) and an update state
// (S_UPD), which registers the result beat; the beat is taken at the edge
// that ends it, and the next command can be taken at that same edge. The
// order is set by the map read before the map write. A receive whose toggle
// differs from the last one first clears the map, one entry a cycle.
// Configuration: cfg_data carries the file length in bytes, written on a cycle
// with cfg_valid and cfg_ready high. A length above SEGMENTS*5 is ignored.
// Otherwise the divider computes the segment count and, outside the reset
// pass, the marks below it are recounted, one map read a cycle, with busy high.
// Reset: a clearing pass walks the whole map with busy high; length writes
// are accepted during that pass.
module file_segment_reassembly #(
  parameter int unsigned SEGMENTS = fsr_pkg::SEGMENTS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire fsr_pkg::in_t                in_data,
  output logic                             busy,
  output logic                             out_valid,
  output fsr_pkg::out_t                    out_data,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [fsr_pkg::SIZE_W-1:0]  cfg_data
);
  import fsr_pkg::*;

  localparam int unsigned AW = $clog2(SEGMENTS);

  logic [AW-1:0]     map_addr;
  logic              map_we;
  logic              map_wd;
  logic              map_rd;
  logic [AW-1:0]     seg_addr;
  logic              seg_we;
  logic [SEG_W-1:0]  seg_wd;
  logic [SEG_W-1:0]  seg_rd;
  logic              div_go;
  logic [SIZE_W-1:0] div_size;
  logic [NEED_W-1:0] div_need;
  logic              div_done;

  fsr_ctrl #(.SEGMENTS(SEGMENTS)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_data   (in_data),
    .busy      (busy),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .map_addr  (map_addr),
    .map_we    (map_we),
    .map_wd    (map_wd),
    .map_rd    (map_rd),
    .seg_addr  (seg_addr),
    .seg_we    (seg_we),
    .seg_wd    (seg_wd),
    .seg_rd    (seg_rd),
    .div_go    (div_go),
    .div_size  (div_size),
    .div_need  (div_need),
    .div_done  (div_done)
  );

  fsr_need_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (div_go),
    .size  (div_size),
    .need  (div_need),
    .done  (div_done)
  );

  fsr_ram #(.W(1), .DEPTH(SEGMENTS)) u_map (
    .clk   (clk),
    .we    (map_we),
    .addr  (map_addr),
    .wdata (map_wd),
    .rdata (map_rd)
  );

  fsr_ram #(.W(SEG_W), .DEPTH(SEGMENTS)) u_store (
    .clk   (clk),
    .we    (seg_we),
    .addr  (seg_addr),
    .wdata (seg_wd),
    .rdata (seg_rd)
  );

endmodule
`default_nettype wire

// ===== rtl/core/fsr_chk.sv =====
// Port-level assertions for the file segment reassembly block, with its bind.
`timescale 1ns / 1ps
`default_nettype none
module fsr_chk (
  input wire logic          clk,
  input wire logic          rst_n,
  input wire logic          start,
  input wire fsr_pkg::in_t  in_data,
  input wire logic          busy,
  input wire logic          out_valid,
  input wire logic          cfg_valid,
  input wire logic          cfg_ready
);
  import fsr_pkg::*;

  // Reset always starts the map clearing pass.
  a_boot_busy: assert property (@(posedge clk) !rst_n |=> busy)
    else $error("block not busy after reset");

  a_acc_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy did not rise after an accepted command");

  // Without a toggle check a command's result beat follows its read and update states.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_data.cmd != CMD_RECV) |-> ##3 out_valid)
    else $error("result beat missing three cycles after a command");

  a_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result beats in adjacent cycles");

  a_cfg_excl: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_valid && cfg_ready) |-> !(start && !busy))
    else $error("length write and command accepted together");

endmodule

bind file_segment_reassembly fsr_chk u_fsr_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .in_data   (in_data),
  .busy      (busy),
  .out_valid (out_valid),
  .cfg_valid (cfg_valid),
  .cfg_ready (cfg_ready)
);
`default_nettype wire

// ===== bench/file_segment_reassembly_test.sv =====
// Self-checking testbench of the file segment reassembly block with its own predictor.
`timescale 1ns / 1ps
module file_segment_reassembly_test;
  import fsr_pkg::*;

  localparam int unsigned SEGS      = SEGMENTS_DEF;
  localparam int unsigned MAX_LEN   = SEGS * SEG_BYTES;
  localparam logic [1:0]  CMD_SPARE = 2'd3;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              start     = 1'b0;
  in_t               in_data   = '0;
  logic              cfg_valid = 1'b0;
  logic [SIZE_W-1:0] cfg_data  = '0;
  logic              busy;
  logic              out_valid;
  logic              cfg_ready;
  out_t              out_data;

  file_segment_reassembly dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_data   (in_data),
    .busy      (busy),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow of the block state, updated as commands are accepted.
  bit                 seg_marked [SEGS];
  logic [SEG_W-1:0]   seg_bytes  [SEGS];
  int unsigned        file_len;
  int unsigned        marked_needed;
  bit                 cur_toggle;
  bit                 delivered_flag;
  bit                 seen_any;

  // Generator view: which entries have been written, so reads never hit an unwritten one.
  bit                 stored_once [SEGS];
  int unsigned        stored_addrs [$];
  bit                 gen_toggle;
  int                 flips_left = 12;
  int unsigned        idle_pct = 16;

  in_t                pending_cmds [$];
  out_t               expected_results [$];
  out_t               want_res;
  int unsigned        mismatch_count;

  function automatic int unsigned segments_needed();
    return (file_len + SEG_BYTES - 1) / SEG_BYTES;
  endfunction

  function automatic void apply_length(int unsigned len);
    if (len <= MAX_LEN) begin
      file_len = len;
      marked_needed = 0;
      for (int unsigned i = 0; i < segments_needed() && i < SEGS; i++)
        if (seg_marked[i]) marked_needed++;
    end
  endfunction

  function automatic out_t predict_segment_result(in_t cmd_beat);
    out_t        res;
    int unsigned a;
    res = '0;
    a = cmd_beat.seg_index;
    case (cmd_beat.cmd)
      CMD_RECV: begin
        seen_any = 1'b1;
        if (cmd_beat.toggle != cur_toggle) begin
          foreach (seg_marked[i]) seg_marked[i] = 1'b0;
          marked_needed = 0;
          delivered_flag = 1'b0;
        end
        cur_toggle = cmd_beat.toggle;
        if (a < SEGS) begin
          seg_bytes[a] = {cmd_beat.block_two[7:0], cmd_beat.block_three, cmd_beat.block_four};
          if (!seg_marked[a] && a < segments_needed()) marked_needed++;
          seg_marked[a] = 1'b1;
        end
      end
      CMD_READ: begin
        if (a < SEGS) begin
          res.segment_present = seg_marked[a];
          {res.byte_zero, res.byte_one, res.byte_two, res.byte_three, res.byte_four} =
            seg_bytes[a];
        end
      end
      CMD_DELIVER: delivered_flag = 1'b1;
      default: ;
    endcase
    res.file_complete = !delivered_flag && file_len != 0 && seen_any &&
                        marked_needed >= segments_needed();
    return res;
  endfunction

  task automatic report_mismatch(string msg);
    mismatch_count++;
    $display("%0t ns: mismatch, %s", $realtime, msg);
  endtask

  task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0h, want %0h", name, got, want));
  endtask

  task automatic queue_cmd(logic [1:0] cmd, bit tog, int unsigned addr,
                           logic [3*BLK_W-1:0] blocks);
    in_t item;
    item.cmd       = cmd;
    item.toggle    = tog;
    item.seg_index = addr[ADDR_W-1:0];
    {item.block_two, item.block_three, item.block_four} = blocks;
    if (cmd == CMD_RECV) begin
      gen_toggle = tog;
      if (item.seg_index < SEGS && !stored_once[item.seg_index]) begin
        stored_once[item.seg_index] = 1'b1;
        stored_addrs.push_back(item.seg_index);
      end
    end
    pending_cmds.push_back(item);
  endtask

  task automatic queue_random(int unsigned count);
    int unsigned need;
    int unsigned pick;
    int unsigned addr;
    bit          wellformed;
    need = segments_needed();
    // Small files can actually be filled; most receives then target the needed range.
    wellformed = need >= 1 && need <= 64;
    repeat (count) begin
      pick = $urandom_range(99);
      if (pick < 55 && wellformed) begin
        queue_cmd(CMD_RECV, gen_toggle, $urandom_range(need - 1),
                  {16'($urandom), 32'($urandom)});
      end else if (pick < 72) begin
        if (stored_addrs.size() != 0 && $urandom_range(3) != 0)
          addr = stored_addrs[$urandom_range(stored_addrs.size() - 1)];
        else
          addr = $urandom_range(65535, SEGS);
        queue_cmd(CMD_READ, 1'($urandom), addr, {16'($urandom), 32'($urandom)});
      end else if (pick < 79) begin
        queue_cmd(CMD_DELIVER, 1'($urandom), $urandom_range(65535),
                  {16'($urandom), 32'($urandom)});
      end else if (pick < 82) begin
        queue_cmd(CMD_SPARE, 1'($urandom), $urandom_range(65535),
                  {16'($urandom), 32'($urandom)});
      end else if (pick < 83 && flips_left > 0) begin
        // A toggle change costs a full clear of the map, so these stay rare.
        flips_left--;
        queue_cmd(CMD_RECV, !gen_toggle, $urandom_range(65535),
                  {16'($urandom), 32'($urandom)});
      end else begin
        addr = $urandom_range(1) ? $urandom_range(SEGS - 1) : $urandom_range(65535);
        queue_cmd(CMD_RECV, gen_toggle, addr, {16'($urandom), 32'($urandom)});
      end
    end
  endtask

  task automatic wait_drained();
    while (pending_cmds.size() != 0 || start || expected_results.size() != 0)
      @(negedge clk);
  endtask

  task automatic write_length(int unsigned len);
    wait_drained();
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= len[SIZE_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    apply_length(len[SIZE_W-1:0]);
    cfg_valid <= 1'b0;
  endtask

  // Command driver: holds start and the beat while busy, then moves to the next item.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!(start && busy)) begin
      if (start) begin
        expected_results.push_back(predict_segment_result(in_data));
        void'(pending_cmds.pop_front());
      end
      if (pending_cmds.size() != 0 && $urandom_range(99) >= idle_pct) begin
        start   <= 1'b1;
        in_data <= pending_cmds[0];
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Result monitor.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result beat with no command outstanding");
      end else begin
        want_res = expected_results.pop_front();
        check_field("file_complete", 8'(out_data.file_complete), 8'(want_res.file_complete));
        check_field("segment_present", 8'(out_data.segment_present),
                    8'(want_res.segment_present));
        check_field("byte_zero", out_data.byte_zero, want_res.byte_zero);
        check_field("byte_one", out_data.byte_one, want_res.byte_one);
        check_field("byte_two", out_data.byte_two, want_res.byte_two);
        check_field("byte_three", out_data.byte_three, want_res.byte_three);
        check_field("byte_four", out_data.byte_four, want_res.byte_four);
      end
    end
  end

  initial begin
    int unsigned phase_len [12];
    phase_len = '{23, 0, 163840, 5, 262143, 6, 100, 163841, 48, 1, 77, 3};
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Length still unknown: out-of-range read, early deliver, spare code, address extremes.
    queue_cmd(CMD_READ, 1'b1, 16'hFFFF, '1);
    queue_cmd(CMD_DELIVER, 1'b0, 0, '0);
    queue_cmd(CMD_SPARE, 1'b1, 16'hFFFF, '1);
    queue_cmd(CMD_RECV, 1'b0, 0, '0);
    queue_cmd(CMD_RECV, 1'b0, SEGS - 1, '1);
    queue_cmd(CMD_RECV, 1'b0, 16'hFFFF, '1);
    queue_cmd(CMD_READ, 1'b0, 0, '0);
    queue_cmd(CMD_READ, 1'b0, SEGS - 1, '0);

    // One-segment file: complete, delivered, then a version change clears the marks.
    write_length(1);
    queue_cmd(CMD_RECV, 1'b0, 0, 48'h5A12_3456_789A);
    queue_cmd(CMD_DELIVER, 1'b0, 0, '0);
    queue_cmd(CMD_RECV, 1'b0, 0, 48'hA5FE_DCBA_9876);
    queue_cmd(CMD_RECV, 1'b1, 1, 48'h0011_2233_4455);
    queue_cmd(CMD_READ, 1'b1, 0, '0);
    queue_cmd(CMD_RECV, 1'b1, 0, 48'hFF00_FF00_FF00);
    queue_cmd(CMD_RECV, 1'b0, SEGS, 48'h00FF_00FF_00FF);
    queue_cmd(CMD_READ, 1'b0, SEGS, '1);
    queue_cmd(CMD_READ, 1'b0, 1, '0);

    foreach (phase_len[p]) begin
      if (p == 4) idle_pct = 45;
      else if (p == 8) idle_pct = 0;
      write_length(phase_len[p]);
      if (p == 5) begin
        queue_random(60);
        wait_drained();
        queue_random(65);
      end else begin
        queue_random(125);
      end
    end

    wait_drained();
    repeat (8) @(negedge clk);
    if (mismatch_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

  initial begin
    #30_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
